// File: design/fcis_pkg.sv
// fcis_pkg: shared types and operation codes for the fixed-capacity integer set
// used by the interfaces, the slot cells and the top level; no dependencies
`default_nettype none

package fcis_pkg;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 9;

    typedef logic [1:0]                 t_op;
    typedef logic signed [VALUE_W-1:0]  t_value;
    typedef logic [INDEX_W-1:0]         t_index;
    typedef logic [COUNT_W-1:0]         t_count;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_REMOVE = 2'd1;
    localparam t_op OP_MEMBER = 2'd2;
    localparam t_op OP_READ   = 2'd3;

    // lookup broadcast to every cell
    typedef struct packed {
        t_value value;
        t_index index;
    } t_probe;

    // update broadcast to every cell
    typedef struct packed {
        logic   ins_en;
        logic   rem_en;
        t_value last_data;
    } t_update;

    // status rippled from cell to cell
    typedef struct packed {
        logic   hit;
        logic   read_hit;
        t_value last_data;
        t_value read_data;
    } t_cell_stat;

endpackage

`default_nettype wire

// File: design/fcis_if.sv
// fcis_in_if / fcis_out_if: valid/ready channels of the integer set
// depends on fcis_pkg
`default_nettype none

interface fcis_in_if;
    import fcis_pkg::*;
    logic   valid;
    logic   ready;
    t_op    operation;
    t_value value;
    t_index index;

    modport source (output valid, output operation, output value, output index, input ready);
    modport sink   (input valid, input operation, input value, input index, output ready);
endinterface

interface fcis_out_if;
    import fcis_pkg::*;
    logic   valid;
    logic   ready;
    logic   result_flag;
    logic   index_error;
    t_value read_value;
    t_count element_count;

    modport source (output valid, output result_flag, output index_error,
                    output read_value, output element_count, input ready);
    modport sink   (input valid, input result_flag, input index_error,
                    input read_value, input element_count, output ready);
endinterface

`default_nettype wire

// File: design/fcis_cell.sv
// fcis_cell: one slot of the set, compares its entry and ripples status onward
// depends on fcis_pkg
`default_nettype none

module fcis_cell #(
    parameter int POS = 0,
    parameter int CNT_W = 4
) (
    input  wire logic                 i_clk,
    input  wire fcis_pkg::t_probe     i_probe,
    input  wire fcis_pkg::t_update    i_upd,
    input  wire logic [CNT_W-1:0]     i_count,
    input  wire fcis_pkg::t_cell_stat i_chain,
    output fcis_pkg::t_cell_stat      o_chain
);
    import fcis_pkg::*;

    localparam logic [CNT_W-1:0]   POS_V  = CNT_W'(POS);
    localparam logic [CNT_W-1:0]   NEXT_V = CNT_W'(POS + 1);
    localparam logic [INDEX_W-1:0] POS_I  = INDEX_W'(POS);

    t_value r_entry;
    logic   held;
    logic   is_last;
    logic   hit;
    logic   read_sel;

    assign held     = POS_V < i_count;
    assign is_last  = NEXT_V == i_count;
    assign hit      = held && (r_entry == i_probe.value);
    assign read_sel = held && (i_probe.index == POS_I);

    always_comb begin
        o_chain.hit       = i_chain.hit | hit;
        o_chain.read_hit  = i_chain.read_hit | read_sel;
        o_chain.last_data = i_chain.last_data | (is_last ? r_entry : '0);
        o_chain.read_data = i_chain.read_data | (read_sel ? r_entry : '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.ins_en && (i_count == POS_V)) begin
            r_entry <= i_probe.value;
        end else if (i_upd.rem_en && hit) begin
            r_entry <= i_upd.last_data;
        end
    end

endmodule

`default_nettype wire

// File: design/fixed_capacity_integer_set.sv
// fixed_capacity_integer_set: top level, a row of slot cells and a result register
// depends on fcis_pkg, fcis_if, fcis_cell
//
// Holds up to CAPACITY distinct signed 32-bit values, one per cell. Every request
// (insert, remove, membership, read by index) is resolved in the cycle it is accepted:
// all cells compare against the value at once and their status ripples along the row,
// so a request is taken every clock unless the output stalls, and its result goes
// to the result register. Requests are accepted while it is empty or being read.
// Remove fills the freed slot with the last held entry, so read order follows it.
`default_nettype none

module fixed_capacity_integer_set #(
    parameter int CAPACITY = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fcis_in_if.sink    i_req,
    fcis_out_if.source o_rsp
);
    import fcis_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAPACITY);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_valid;
    logic             r_flag;
    logic             r_ierr;
    t_value           r_rval;
    t_count           r_ecnt;

    logic             accept;
    logic             flag;
    logic             ierr;
    t_value           rval;
    t_probe           probe;
    t_update          upd;
    t_cell_stat       chain [CAPACITY+1];

    assign i_req.ready = !r_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign probe.value = i_req.value;
    assign probe.index = i_req.index;
    assign chain[0]    = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        fcis_cell #(.POS(g), .CNT_W(CNT_W)) u_cell (
            .i_clk   (i_clk),
            .i_probe (probe),
            .i_upd   (upd),
            .i_count (r_count),
            .i_chain (chain[g]),
            .o_chain (chain[g+1])
        );
    end

    always_comb begin
        flag           = 1'b0;
        ierr           = 1'b0;
        rval           = '0;
        n_count        = r_count;
        upd.ins_en     = 1'b0;
        upd.rem_en     = 1'b0;
        upd.last_data  = chain[CAPACITY].last_data;
        case (i_req.operation)
            OP_INSERT: begin
                flag = !chain[CAPACITY].hit && (r_count < CAP_V);
                if (flag) begin
                    n_count = r_count + 1'b1;
                end
                upd.ins_en = accept && flag;
            end
            OP_REMOVE: begin
                flag = chain[CAPACITY].hit;
                if (flag) begin
                    n_count = r_count - 1'b1;
                end
                upd.rem_en = accept && flag;
            end
            OP_MEMBER: begin
                flag = chain[CAPACITY].hit;
            end
            OP_READ: begin
                ierr = !chain[CAPACITY].read_hit;
                rval = chain[CAPACITY].read_data;
            end
            default: begin
                flag = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_flag <= flag;
            r_ierr <= ierr;
            r_rval <= rval;
            r_ecnt <= COUNT_W'(n_count);
        end
    end

    assign o_rsp.valid         = r_valid;
    assign o_rsp.result_flag   = r_flag;
    assign o_rsp.index_error   = r_ierr;
    assign o_rsp.read_value    = r_rval;
    assign o_rsp.element_count = r_ecnt;

endmodule

`default_nettype wire

// File: design/fcis_checker.sv
// fcis_checker: port-level assertions for the integer set, bound to the top level
// depends on fcis_pkg and fixed_capacity_integer_set
`default_nettype none

module fcis_checker #(
    parameter int CAPACITY = 8
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  i_in_ready,
    input wire logic                  i_out_valid,
    input wire logic                  i_out_ready,
    input wire logic                  i_result_flag,
    input wire logic                  i_index_error,
    input wire fcis_pkg::t_value      i_read_value,
    input wire fcis_pkg::t_count      i_element_count
);
    import fcis_pkg::*;

    localparam t_count CAP_C = COUNT_W'(CAPACITY);

    // stalled transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_element_count <= CAP_C)
        else $error("element count above capacity");

    a_ierr_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_index_error |-> !i_result_flag && i_read_value == '0)
        else $error("index error with flag or data");

    // each accepted transaction yields a result next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted transaction gave no result");

endmodule

bind fixed_capacity_integer_set fcis_checker #(.CAPACITY(CAPACITY)) u_fcis_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_req.valid),
    .i_in_ready      (i_req.ready),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_result_flag   (o_rsp.result_flag),
    .i_index_error   (o_rsp.index_error),
    .i_read_value    (o_rsp.read_value),
    .i_element_count (o_rsp.element_count)
);

`default_nettype wire

// File: bench/tb_fixed_capacity_integer_set.sv
// tb_fixed_capacity_integer_set: self-checking bench for the fixed-capacity integer set
// drives requests on fcis_in_if and scores results on fcis_out_if against its own set model
// depends on fcis_pkg, fcis_if and fixed_capacity_integer_set
`default_nettype none

module tb_fixed_capacity_integer_set;
    timeunit 1ns;
    timeprecision 1ps;

    import fcis_pkg::*;

    localparam int SET_CAPACITY   = 8;
    localparam int POOL_SIZE      = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_ITEMS    = 100;

    typedef struct packed {
        logic   flag;
        logic   ierr;
        t_value rval;
        t_count count;
    } t_set_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fcis_in_if  req_if ();
    fcis_out_if rsp_if ();

    fixed_capacity_integer_set #(
        .CAPACITY(SET_CAPACITY)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    always #2 i_clk = ~i_clk;

    // set model
    t_value      model_slots [SET_CAPACITY];
    int          model_size;
    t_set_result pending_results [$];
    t_set_result want;

    t_value value_pool [POOL_SIZE];
    bit     send_idle;
    bit     recv_idle;
    int     hold_request;
    int     mismatches;
    int     idle_cycles;
    int     requests_seen;
    int     results_seen;
    int     op_seen [4];
    int     rejected_full;
    int     rejected_dup;

    function automatic t_set_result apply_set_op(t_op op, t_value v, t_index idx);
        t_set_result r;
        int hit;
        int i;
        r = '0;
        hit = -1;
        for (i = 0; i < model_size; i++) begin
            if (hit < 0 && model_slots[i] == v) hit = i;
        end
        case (op)
            OP_INSERT: begin
                if (model_size >= SET_CAPACITY) begin
                    rejected_full++;
                end else if (hit >= 0) begin
                    rejected_dup++;
                end else begin
                    model_slots[model_size] = v;
                    model_size++;
                    r.flag = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (hit >= 0) begin
                    model_slots[hit] = model_slots[model_size-1];
                    model_size--;
                    r.flag = 1'b1;
                end
            end
            OP_MEMBER: begin
                r.flag = (hit >= 0);
            end
            default: begin
                if (idx < model_size) r.rval = model_slots[idx];
                else r.ierr = 1'b1;
            end
        endcase
        r.count = t_count'(model_size);
        return r;
    endfunction

    // result scoreboard and request capture
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result transaction: count %0d",
                                 rsp_if.element_count);
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_if.result_flag !== want.flag || rsp_if.index_error !== want.ierr ||
                        rsp_if.read_value !== want.rval ||
                        rsp_if.element_count !== want.count) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("result %0d mismatch: flag %b/%b ierr %b/%b value %0d/%0d count %0d/%0d (exp/act)",
                                     results_seen, want.flag, rsp_if.result_flag,
                                     want.ierr, rsp_if.index_error,
                                     want.rval, rsp_if.read_value,
                                     want.count, rsp_if.element_count);
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                requests_seen++;
                op_seen[req_if.operation]++;
                pending_results.push_back(apply_set_op(req_if.operation, req_if.value,
                                                       req_if.index));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // result side: random stalls plus an optional long hold
    initial begin
        int gap;
        int hold;
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            if (hold_request > 0) begin
                hold = hold_request;
                hold_request = 0;
                repeat (hold) begin
                    @(negedge i_clk);
                    rsp_if.ready <= 1'b0;
                end
            end
            gap = recv_idle ? $urandom_range(0, 6) : 0;
            repeat (gap) begin
                @(negedge i_clk);
                rsp_if.ready <= 1'b0;
            end
            @(negedge i_clk);
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_if.valid && rsp_if.ready));
        end
    end

    task automatic send_request(t_op op, t_value v, t_index idx);
        int gap;
        gap = send_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.value     <= v;
        req_if.index     <= idx;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
    endtask

    // stop offering before waiting so the last transaction is not taken twice
    task automatic wait_results_drained();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
    endtask

    function automatic t_value pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 && model_size > 0) return model_slots[$urandom_range(0, model_size - 1)];
        if (r < 9) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return t_value'($urandom);
    endfunction

    function automatic t_index pick_index();
        if ($urandom_range(0, 9) < 7) return t_index'($urandom_range(0, SET_CAPACITY));
        return t_index'($urandom_range(0, 255));
    endfunction

    task automatic test_empty_set();
        send_request(OP_READ, 0, 0);
        send_request(OP_REMOVE, 0, 0);
        send_request(OP_MEMBER, 0, 0);
    endtask

    task automatic test_insert_lookup();
        send_request(OP_INSERT, 32'sh8000_0000, 0);
        send_request(OP_INSERT, 32'sh7fff_ffff, 0);
        send_request(OP_INSERT, 0, 8'hff);
        send_request(OP_INSERT, -1, 0);
        send_request(OP_INSERT, 32'sh7fff_ffff, 0);
        send_request(OP_MEMBER, -1, 0);
        send_request(OP_MEMBER, 5, 0);
        send_request(OP_READ, 0, 0);
        send_request(OP_READ, 0, 3);
        send_request(OP_READ, 0, 4);
        send_request(OP_READ, 0, 8'hff);
    endtask

    task automatic test_capacity_limit();
        send_request(OP_INSERT, 1, 0);
        send_request(OP_INSERT, 2, 0);
        send_request(OP_INSERT, 3, 0);
        send_request(OP_INSERT, 4, 0);
        send_request(OP_INSERT, 9, 0);
        send_request(OP_READ, 0, 7);
    endtask

    task automatic test_remove_compaction();
        send_request(OP_REMOVE, 32'sh7fff_ffff, 0);
        send_request(OP_READ, 0, 1);
        send_request(OP_READ, 0, 7);
        send_request(OP_REMOVE, 123, 0);
        send_request(OP_MEMBER, 32'sh7fff_ffff, 0);
    endtask

    // output side held off while requests keep coming
    task automatic test_stall_fill();
        int n;
        send_idle = 1'b0;
        hold_request = 40;
        for (n = 0; n < 12; n++) begin
            if (n % 2 == 0) send_request(OP_INSERT, pick_value(), 0);
            else send_request(OP_READ, 0, pick_index());
        end
    endtask

    task automatic test_random_ops();
        int p;
        int n;
        int r;
        int ins_w;
        int rem_w;
        int mem_w;
        for (p = 0; p < RANDOM_PHASES; p++) begin
            send_idle = (p % 3 != 1) && (p != 4);
            recv_idle = (p % 3 != 2) && (p != 4);
            case (p % 3)
                0: begin ins_w = 55; rem_w = 15; mem_w = 15; end
                1: begin ins_w = 20; rem_w = 45; mem_w = 15; end
                default: begin ins_w = 35; rem_w = 25; mem_w = 20; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < ins_w) send_request(OP_INSERT, pick_value(), pick_index());
                else if (r < ins_w + rem_w) send_request(OP_REMOVE, pick_value(), pick_index());
                else if (r < ins_w + rem_w + mem_w)
                    send_request(OP_MEMBER, pick_value(), pick_index());
                else send_request(OP_READ, t_value'($urandom), pick_index());
            end
            if (p == 5) wait_results_drained();
        end
    endtask

    initial begin
        int i;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.operation = OP_INSERT;
        req_if.value     = '0;
        req_if.index     = '0;
        rsp_if.ready     = 1'b0;
        model_size       = 0;
        hold_request     = 0;
        mismatches       = 0;
        idle_cycles      = 0;
        requests_seen    = 0;
        results_seen     = 0;
        rejected_full    = 0;
        rejected_dup     = 0;
        send_idle        = 1'b1;
        recv_idle        = 1'b1;
        for (i = 0; i < 4; i++) op_seen[i] = 0;
        for (i = 0; i < SET_CAPACITY; i++) model_slots[i] = '0;
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = 0;
        value_pool[3] = -1;
        for (i = 4; i < POOL_SIZE; i++) value_pool[i] = t_value'($urandom);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_set();
        test_insert_lookup();
        test_capacity_limit();
        test_remove_compaction();
        wait_results_drained();
        test_stall_fill();
        wait_results_drained();
        test_random_ops();

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        wait_results_drained();
        repeat (8) @(posedge i_clk);

        $display("covered %0d requests (insert %0d, remove %0d, member %0d, read %0d), %0d results",
                 requests_seen, op_seen[OP_INSERT], op_seen[OP_REMOVE], op_seen[OP_MEMBER],
                 op_seen[OP_READ], results_seen);
        $display("inserts refused: %0d on a full set, %0d as duplicates; %0d mismatches",
                 rejected_full, rejected_dup, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
